FILE: design/stsir_pkg.sv
// ----------------------------------------------------------------------------
// stsir_pkg
// Shared types and codes for the sorted key table with search, insert and
// remove.
// ----------------------------------------------------------------------------
package stsir_pkg;

    localparam int TYPE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 10;
    localparam int CNT_W    = 11;

    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_HEAD,
        S_BS_READ,
        S_BS_CMP,
        S_RM_SHIFT,
        S_DONE
    } t_state;

endpackage

FILE: design/stsir_if.sv
// ----------------------------------------------------------------------------
// stsir_if
// Request and response channels of the sorted key table, valid/ready
// handshake with the payload fields.
// ----------------------------------------------------------------------------
interface stsir_req_if import stsir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [TYPE_W-1:0]       req_type;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink (input valid, input req_type, input key, output ready);
endinterface

interface stsir_rsp_if import stsir_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    step_count;
    logic [CNT_W-1:0]    entries_held;

    modport source (output valid, output status, output position, output step_count,
                    output entries_held, input ready);
    modport sink (input valid, input status, input position, input step_count,
                  input entries_held, output ready);
endinterface

FILE: design/sorted_table_search_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_table_search_insert_remove
// Ascending table of signed 64-bit keys in one single-port-write,
// registered-read memory, driven by a small sequencer and one comparator.
// Inserts into an empty or full table and unused requests go straight to the
// done state; other inserts shift larger entries up from the tail, search and
// remove run a binary search over read and compare states, and a remove hit
// then shifts the entries above it down. One transaction is processed at a time
// and a held response stalls the next one; the tail shift moves one entry per
// cycle through the memory ports. Reset clears the entry count and the control
// state; the key memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_remove import stsir_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stsir_req_if.sink     i_req,
    stsir_rsp_if.source   o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = CW + 1;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic [CW-1:0]           r_count, n_count;
    logic [TYPE_W-1:0]       r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_probes, n_probes;
    logic                    r_moved, n_moved;
    logic [STATUS_W-1:0]     r_res_status, n_res_status;
    logic [AW-1:0]           r_res_pos, n_res_pos;
    logic [EW-1:0]           r_res_steps, n_res_steps;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [POS_W-1:0]        r_out_position;
    logic [CNT_W-1:0]        r_out_step_count;
    logic [CNT_W-1:0]        r_out_entries_held;

    logic [KEY_W-1:0]        r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]        r_rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [KEY_W-1:0]        wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;

    logic                    req_fire;
    logic                    out_free;
    logic                    key_less;
    logic                    key_equal;
    logic [EW-1:0]           mid_sum;
    logic [AW-1:0]           mid;
    logic [EW-1:0]           idx_p1;
    logic [EW-1:0]           idx_p2;
    logic [EW-1:0]           count_e;

    assign req_fire   = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign key_less   = r_key < $signed(r_rd_data);
    assign key_equal  = r_rd_data == r_key;
    assign mid_sum    = EW'(r_lo) + EW'(r_hi) - EW'(1);
    assign mid        = AW'(mid_sum >> 1);
    assign idx_p1     = EW'(r_idx) + EW'(1);
    assign idx_p2     = EW'(r_idx) + EW'(2);
    assign count_e    = EW'(r_count);

    assign i_req.ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_count == FULL_COUNT || r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_INS_SHIFT;
                            end
                        end
                        REQ_SEARCH, REQ_REMOVE: n_state = S_BS_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_SHIFT: begin
                if (!key_less) begin
                    n_state = S_DONE;
                end else if (r_idx == '0) begin
                    n_state = S_INS_HEAD;
                end
            end
            S_INS_HEAD: n_state = S_DONE;
            S_BS_READ: begin
                n_state = (r_lo >= r_hi) ? S_DONE : S_BS_CMP;
            end
            S_BS_CMP: begin
                if (!key_equal) begin
                    n_state = S_BS_READ;
                end else if (r_op == REQ_REMOVE && idx_p1 < count_e) begin
                    n_state = S_RM_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_SHIFT: begin
                if (idx_p2 >= count_e) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count      = r_count;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_probes     = r_probes;
        n_moved      = r_moved;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_steps  = r_res_steps;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_rd_data;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op         = i_req.req_type;
                    n_key        = i_req.key;
                    n_lo         = '0;
                    n_hi         = r_count;
                    n_probes     = '0;
                    n_moved      = 1'b0;
                    n_res_status = STATUS_NOT_FOUND;
                    n_res_pos    = '0;
                    n_res_steps  = '0;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_count == FULL_COUNT) begin
                                n_res_status = STATUS_FULL;
                            end else if (r_count == '0) begin
                                wr_en        = 1'b1;
                                wr_addr      = '0;
                                wr_data      = i_req.key;
                                n_res_status = STATUS_OK;
                                n_res_steps  = EW'(1);
                                n_count      = CW'(1);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count - CW'(1));
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_p1);
                if (!key_less) begin
                    wr_data      = r_key;
                    n_res_status = STATUS_OK;
                    n_res_pos    = AW'(idx_p1);
                    n_res_steps  = r_moved ? (count_e + EW'(1)) : EW'(1);
                    n_count      = r_count + CW'(1);
                end else begin
                    wr_data = r_rd_data;
                    n_moved = 1'b1;
                    if (r_idx != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                    end
                end
            end
            S_INS_HEAD: begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = r_key;
                n_res_status = STATUS_OK;
                n_res_pos    = '0;
                n_res_steps  = count_e + EW'(1);
                n_count      = r_count + CW'(1);
            end
            S_BS_READ: begin
                if (r_lo >= r_hi) begin
                    n_res_status = STATUS_NOT_FOUND;
                    n_res_pos    = '0;
                    n_res_steps  = (r_op == REQ_SEARCH) ? EW'(r_probes) : '0;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = mid;
                    n_idx    = mid;
                    n_probes = r_probes + CW'(1);
                end
            end
            S_BS_CMP: begin
                if (key_equal) begin
                    n_res_status = STATUS_OK;
                    n_res_pos    = r_idx;
                    if (r_op == REQ_SEARCH) begin
                        n_res_steps = EW'(r_probes);
                    end else if (idx_p1 < count_e) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_p1);
                    end else begin
                        n_res_steps = EW'(r_probes) + count_e - idx_p1;
                        n_count     = r_count - CW'(1);
                    end
                end else if (!key_less) begin
                    n_lo = CW'(idx_p1);
                end else begin
                    n_hi = CW'(r_idx);
                end
            end
            S_RM_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rd_data;
                if (idx_p2 < count_e) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_p2);
                    n_idx   = AW'(idx_p1);
                end else begin
                    n_res_steps = EW'(r_probes) + count_e - EW'(r_res_pos) - EW'(1);
                    n_count     = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_probes     <= n_probes;
        r_moved      <= n_moved;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_steps  <= n_res_steps;
        if (r_state == S_DONE && out_free) begin
            r_out_status       <= r_res_status;
            r_out_position     <= POS_W'(r_res_pos);
            r_out_step_count   <= CNT_W'(r_res_steps);
            r_out_entries_held <= CNT_W'(r_count);
        end
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.position     = r_out_position;
    assign o_rsp.step_count   = r_out_step_count;
    assign o_rsp.entries_held = r_out_entries_held;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above table depth");

    a_head_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_HEAD |=> r_count == $past(r_count) + CW'(1))
        else $error("head insert did not grow the table");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BS_CMP |-> (r_lo < r_hi && CW'(r_idx) >= r_lo && CW'(r_idx) < r_hi))
        else $error("probe outside search window");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not moved to response register");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted key table. Requests go in and responses
// come out over valid/ready channels, with random gaps on both sides. A
// scoreboard keeps its own sorted copy of the table and queues the expected
// response for every request that is taken. The run starts with edge cases
// and continues with random traffic whose keys are mostly drawn from those held.
// ----------------------------------------------------------------------------
module testbench;
    import stsir_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int RANDOM_ITEMS   = 557;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [TYPE_W-1:0]       REQ_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN    = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX    = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    step_count;
        logic [CNT_W-1:0]    entries_held;
    } t_table_answer;

    class key_table_scoreboard;
        logic signed [KEY_W-1:0] key_store [DEPTH];
        int                      held;
        t_table_answer           answers_due [$];
        int                      errors;
        int                      reported;

        function int binary_probe(logic signed [KEY_W-1:0] k, output int probes);
            int lo;
            int hi;
            int mid;
            probes = 0;
            lo = 0;
            hi = held - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                probes++;
                if (key_store[mid] == k)
                    return mid;
                if (key_store[mid] < k)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return -1;
        endfunction

        function void note_request(logic [TYPE_W-1:0] kind, logic signed [KEY_W-1:0] k);
            t_table_answer a;
            int            at;
            int            probes;
            int            idx;
            a.status     = STATUS_NOT_FOUND;
            a.position   = '0;
            a.step_count = '0;
            case (kind)
                REQ_INSERT: begin
                    if (held >= DEPTH) begin
                        a.status = STATUS_FULL;
                    end else begin
                        idx = held;
                        a.step_count = CNT_W'(1);
                        if (held != 0 && k < key_store[held-1]) begin
                            idx = 0;
                            while (idx < held && !(k < key_store[idx]))
                                idx++;
                            for (int i = held; i > idx; i--)
                                key_store[i] = key_store[i-1];
                            a.step_count = CNT_W'(held + 1);
                        end
                        key_store[idx] = k;
                        held++;
                        a.status   = STATUS_OK;
                        a.position = POS_W'(idx);
                    end
                end
                REQ_SEARCH: begin
                    at = binary_probe(k, probes);
                    a.step_count = CNT_W'(probes);
                    if (at >= 0) begin
                        a.status   = STATUS_OK;
                        a.position = POS_W'(at);
                    end
                end
                REQ_REMOVE: begin
                    at = binary_probe(k, probes);
                    if (at >= 0) begin
                        for (int i = at; i + 1 < held; i++)
                            key_store[i] = key_store[i+1];
                        a.step_count = CNT_W'(probes + held - 1 - at);
                        a.position   = POS_W'(at);
                        a.status     = STATUS_OK;
                        held--;
                    end
                end
                default: ;
            endcase
            a.entries_held = CNT_W'(held);
            answers_due.push_back(a);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                                   logic [CNT_W-1:0] step_count, logic [CNT_W-1:0] entries_held);
            t_table_answer want;
            if (answers_due.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected response: status %0d position %0d steps %0d held %0d",
                             status, position, step_count, entries_held);
                end
                return;
            end
            want = answers_due.pop_front();
            if (status !== want.status || position !== want.position ||
                step_count !== want.step_count || entries_held !== want.entries_held) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: expected status %0d position %0d steps %0d held %0d",
                             want.status, want.position, want.step_count, want.entries_held);
                    $display("          got      status %0d position %0d steps %0d held %0d",
                             status, position, step_count, entries_held);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   burst_left;
    int   quiet_cycles;

    key_table_scoreboard sb = new;

    stsir_req_if req_ch ();
    stsir_rsp_if rsp_ch ();

    sorted_table_search_insert_remove #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // mostly short gaps, some long, and now and then a run without any
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_request(input logic [TYPE_W-1:0] kind,
                                input logic signed [KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key      <= k;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(kind, k);
    endtask

    initial begin : rsp_ready_driver
        int stall;
        rsp_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.position, rsp_ch.step_count,
                            rsp_ch.entries_held);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                      r;
        int                      v;
        logic [TYPE_W-1:0]       kind;
        logic signed [KEY_W-1:0] k;

        i_rst_n         = 1'b0;
        burst_left      = 0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, duplicates, misses, unused request type
        send_request(REQ_SEARCH, 0);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, 64'sh5555_5555_5555_5555);
        send_request(REQ_INSERT, 64'shAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_SEARCH, KEY_MIN);
        send_request(REQ_SEARCH, KEY_MAX);
        send_request(REQ_SEARCH, 0);
        send_request(REQ_SEARCH, 3);
        send_request(REQ_REMOVE, KEY_MAX);
        send_request(REQ_REMOVE, KEY_MIN);
        send_request(REQ_REMOVE, 3);
        send_request(REQ_UNUSED, 64'shAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_UNUSED, KEY_MAX);
        send_request(REQ_SEARCH, 64'shAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, 0);

        // random traffic, keys mostly drawn from the table contents
        repeat (RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                kind = REQ_UNUSED;
            else if (r < 45)
                kind = REQ_INSERT;
            else if (r < 72)
                kind = REQ_SEARCH;
            else
                kind = REQ_REMOVE;
            r = $urandom_range(0, 99);
            if (sb.held > 0 && r < 55) begin
                k = sb.key_store[$urandom_range(0, sb.held - 1)];
                if (r >= 45)
                    k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
            end else if (r < 80) begin
                v = $urandom_range(0, 40);
                k = v - 20;
            end else begin
                k = {$urandom, $urandom};
            end
            send_request(kind, k);
        end
        req_ch.valid <= 1'b0;

        while (sb.answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
design/stsir_pkg.sv
design/stsir_if.sv
design/sorted_table_search_insert_remove.sv
sim/testbench.sv
